// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the transform unit.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, also active during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/htu_pkg.sv =====
// Package of the homogeneous transform unit: fixed-point sizes, opcodes, types.
// No dependencies.
`default_nettype none

package htu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int TRUNC_W   = PROD_W - FRAC_BITS;
  localparam int SUM_W     = TRUNC_W + 2;

  typedef logic signed [DATA_W-1:0] elem_t;
  typedef elem_t mat_t [0:3][0:3];

  localparam elem_t ONE_Q    = elem_t'(1) <<< FRAC_BITS;
  localparam elem_t ZERO_Q   = '0;
  localparam elem_t ELEM_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam elem_t ELEM_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [3:0] {
    OP_CLEAR     = 4'd0,
    OP_IDENTITY  = 4'd1,
    OP_SET       = 4'd2,
    OP_TRANSLATE = 4'd3,
    OP_SCALE     = 4'd4,
    OP_ROTX      = 4'd5,
    OP_ROTY      = 4'd6,
    OP_ROTZ      = 4'd7,
    OP_BASIS     = 4'd8,
    OP_SHEARZ    = 4'd9,
    OP_SHEAR2D   = 4'd10,
    OP_PERSP     = 4'd11,
    OP_TRANSPOSE = 4'd12,
    OP_TRANSFORM = 4'd13,
    OP_READ      = 4'd14,
    OP_NONE      = 4'd15
  } op_t;

endpackage

`default_nettype wire

// ===== sv/htu_matmul.sv =====
// 4x4 fixed-point matrix product with truncated products and saturated sums.
// Depends on htu_pkg.
`default_nettype none

module htu_matmul
  import htu_pkg::*;
(
  input  elem_t a_mat [0:3][0:3],
  input  elem_t b_mat [0:3][0:3],
  output elem_t p_mat [0:3][0:3],
  output logic  sat
);

  logic signed [PROD_W-1:0] prod [0:3][0:3][0:3];
  logic signed [SUM_W-1:0]  acc  [0:3][0:3];
  logic [15:0]              sat_bits;

  // Each element: four exact products floored by FRAC_BITS, summed, clamped to 32 bits.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        acc[i][j] = '0;
        for (int k = 0; k < 4; k++) begin
          prod[i][j][k] = PROD_W'(a_mat[i][k]) * PROD_W'(b_mat[k][j]);
          acc[i][j] = acc[i][j] + SUM_W'($signed(prod[i][j][k][PROD_W-1:FRAC_BITS]));
        end
        sat_bits[i*4+j] = !((&acc[i][j][SUM_W-1:DATA_W-1]) ||
                            !(|acc[i][j][SUM_W-1:DATA_W-1]));
        if (sat_bits[i*4+j]) begin
          p_mat[i][j] = acc[i][j][SUM_W-1] ? ELEM_MIN : ELEM_MAX;
        end else begin
          p_mat[i][j] = acc[i][j][DATA_W-1:0];
        end
      end
    end
  end

  assign sat = |sat_bits;

endmodule

`default_nettype wire

// ===== sv/homogeneous_transform_unit.sv =====
// Top level of the homogeneous 4x4 transform unit: input register, matrix state,
// result register. Depends on htu_pkg, htu_matmul and assert_macros.svh.
//
//  channel | dir | tdata                                  | tuser
//  in_     | in  | row, col, arg0..arg8 (296 bits)        | opcode
//  out_    | out | res0..res3 (128 bits)                  | saturated
//
// Each request is held in the input register and then lands in the
// result register; one request per cycle is sustained while the result is
// not stalled, with a single matrix-product array between the two registers.
// Reset loads the identity matrix and empties both registers.
// A stalled result holds the input register; new requests wait only then.
`default_nettype none
`include "assert_macros.svh"

module homogeneous_transform_unit
  import htu_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // row_sel[1:0], col_sel[3:2], arg0..arg8 at [4+32k +: 32], zero pad [295:292]
  input  wire logic [295:0] in_tdata,
  // opcode[3:0]
  input  wire logic [3:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // res0[31:0], res1[63:32], res2[95:64], res3[127:96]
  output logic [127:0]      out_tdata,
  // saturated[0]
  output logic [0:0]        out_tuser
);

  logic        item_valid_r;
  op_t         op_r;
  logic [1:0]  row_r;
  logic [1:0]  col_r;
  elem_t       arg_r [0:8];
  elem_t       mtx_r [0:3][0:3];
  elem_t       mtx_nxt [0:3][0:3];
  logic        out_valid_r;
  logic [127:0] out_data_r;
  logic        out_sat_r;

  logic        advance;
  logic        fire;
  elem_t       t_mat [0:3][0:3];
  elem_t       a_sel [0:3][0:3];
  elem_t       b_sel [0:3][0:3];
  elem_t       p_mat [0:3][0:3];
  logic        mm_sat;
  elem_t       neg_sin;
  logic        neg_ovf;
  logic        premult;
  logic [127:0] data_nxt;
  logic        sat_nxt;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = item_valid_r && advance;
  assign in_tready = !item_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tready) begin
      item_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      op_r  <= op_t'(in_tuser);
      row_r <= in_tdata[1:0];
      col_r <= in_tdata[3:2];
      for (int k = 0; k < 9; k++) begin
        arg_r[k] <= in_tdata[4 + 32*k +: 32];
      end
    end
  end

  // Negated sine, clamped when the sine is the most negative value.
  assign neg_ovf = (arg_r[1] == ELEM_MIN);
  assign neg_sin = neg_ovf ? ELEM_MAX : -arg_r[1];

  // Left-hand matrix for the premultiply opcodes.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 4; k++) begin
        t_mat[i][k] = (i == k) ? ONE_Q : ZERO_Q;
      end
    end
    premult = 1'b1;
    case (op_r)
      OP_TRANSLATE: begin
        t_mat[0][3] = arg_r[0]; t_mat[1][3] = arg_r[1]; t_mat[2][3] = arg_r[2];
      end
      OP_SCALE: begin
        t_mat[0][0] = arg_r[0]; t_mat[1][1] = arg_r[1]; t_mat[2][2] = arg_r[2];
      end
      OP_ROTX: begin
        t_mat[1][1] = arg_r[0]; t_mat[1][2] = neg_sin;
        t_mat[2][1] = arg_r[1]; t_mat[2][2] = arg_r[0];
      end
      OP_ROTY: begin
        t_mat[0][0] = arg_r[0]; t_mat[0][2] = arg_r[1];
        t_mat[2][0] = neg_sin;  t_mat[2][2] = arg_r[0];
      end
      OP_ROTZ: begin
        t_mat[0][0] = arg_r[0]; t_mat[0][1] = neg_sin;
        t_mat[1][0] = arg_r[1]; t_mat[1][1] = arg_r[0];
      end
      OP_BASIS: begin
        for (int i = 0; i < 3; i++) begin
          for (int k = 0; k < 3; k++) begin
            t_mat[i][k] = arg_r[i*3 + k];
          end
        end
      end
      OP_SHEARZ: begin
        t_mat[0][2] = arg_r[0]; t_mat[1][2] = arg_r[1];
      end
      OP_SHEAR2D: begin
        t_mat[0][1] = arg_r[0]; t_mat[1][0] = arg_r[1];
      end
      OP_PERSP: begin
        t_mat[3][3] = ZERO_Q; t_mat[3][2] = arg_r[0];
      end
      default: premult = 1'b0;
    endcase
  end

  // The product array serves both premultiply (T * M) and transform (M * point).
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        if (op_r == OP_TRANSFORM) begin
          a_sel[i][j] = mtx_r[i][j];
          b_sel[i][j] = (j == 0) ? arg_r[i] : ZERO_Q;
        end else begin
          a_sel[i][j] = t_mat[i][j];
          b_sel[i][j] = mtx_r[i][j];
        end
      end
    end
  end

  htu_matmul u_matmul (
    .a_mat (a_sel),
    .b_mat (b_sel),
    .p_mat (p_mat),
    .sat   (mm_sat)
  );

  // Next matrix, result data and saturation flag.
  always_comb begin
    mtx_nxt  = mtx_r;
    data_nxt = '0;
    sat_nxt  = 1'b0;
    if (premult) begin
      mtx_nxt = p_mat;
      sat_nxt = mm_sat ||
                (neg_ovf && (op_r == OP_ROTX || op_r == OP_ROTY || op_r == OP_ROTZ));
    end
    case (op_r)
      OP_CLEAR: begin
        for (int i = 0; i < 4; i++) begin
          for (int j = 0; j < 4; j++) begin
            mtx_nxt[i][j] = ZERO_Q;
          end
        end
      end
      OP_IDENTITY: begin
        for (int i = 0; i < 4; i++) begin
          for (int j = 0; j < 4; j++) begin
            mtx_nxt[i][j] = (i == j) ? ONE_Q : ZERO_Q;
          end
        end
      end
      OP_SET: mtx_nxt[row_r][col_r] = arg_r[0];
      OP_TRANSPOSE: begin
        for (int i = 0; i < 4; i++) begin
          for (int j = 0; j < 4; j++) begin
            mtx_nxt[i][j] = mtx_r[j][i];
          end
        end
      end
      OP_TRANSFORM: begin
        for (int i = 0; i < 4; i++) begin
          data_nxt[32*i +: 32] = p_mat[i][0];
        end
        sat_nxt = mm_sat;
      end
      OP_READ: data_nxt[31:0] = mtx_r[row_r][col_r];
      default: ;
    endcase
  end

  // Matrix state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          mtx_r[i][j] <= (i == j) ? ONE_Q : ZERO_Q;
        end
      end
    end else begin
      if (advance) begin
        out_valid_r <= item_valid_r;
      end
      if (fire) begin
        mtx_r <= mtx_nxt;
      end
    end
    if (fire) begin
      out_data_r <= data_nxt;
      out_sat_r  <= sat_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_sat_r;

  // A request held back by a stalled result stays in the input register.
  `ASSERT_CLK(a_hold_item, (item_valid_r && !advance) |=> item_valid_r, "request lost in stall")
  // A read returns the element that the matrix held when it executed.
  `ASSERT_CLK(a_read_elem, (fire && op_r == OP_READ) |=> (out_data_r[31:0] == $past(mtx_r[row_r][col_r])), "read returned wrong element")
  // Loading identity puts one on the diagonal.
  `ASSERT_CLK(a_identity, (fire && op_r == OP_IDENTITY) |=> (mtx_r[2][2] == ONE_Q && mtx_r[0][3] == ZERO_Q), "identity load failed")

endmodule

`default_nettype wire

// ===== tb/htu_checker.sv =====
// Scoreboard for the homogeneous transform unit: watches both stream channels,
// keeps its own copy of the matrix and compares every result. Depends on htu_pkg.
module htu_checker
  import htu_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [295:0] in_tdata,
  input  logic [3:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [127:0] out_tdata,
  input  logic [0:0]   out_tuser,
  output int           fail_count,
  output int           pending_count
);

  typedef struct packed {
    logic signed [31:0] r3, r2, r1, r0;
    logic               sat;
  } htu_result_t;

  logic signed [31:0] shadow_m [0:3][0:3];
  htu_result_t        expected_results [$];
  logic               sat_seen;

  assign pending_count = expected_results.size();

  // Product of two Q16.16 values, floored by the fraction bits.
  function automatic logic signed [63:0] fx_mul(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return p >>> FRAC_BITS;
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      sat_seen = 1'b1;
      return ELEM_MAX;
    end
    if (v < -66'sd2147483648) begin
      sat_seen = 1'b1;
      return ELEM_MIN;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] negate(logic signed [31:0] v);
    if (v == ELEM_MIN) begin
      sat_seen = 1'b1;
      return ELEM_MAX;
    end
    return -v;
  endfunction

  // Apply one request to the shadow matrix and return its result.
  function automatic htu_result_t apply_request(op_t op, logic [1:0] r, logic [1:0] c,
                                                 logic signed [31:0] a [0:8]);
    logic signed [31:0] t [0:3][0:3];
    logic signed [31:0] nm [0:3][0:3];
    logic signed [31:0] x;
    logic signed [65:0] s;
    htu_result_t        res;
    bit                 premul;
    res = '0;
    sat_seen = 1'b0;
    premul = 1'b1;
    for (int i = 0; i < 4; i++)
      for (int k = 0; k < 4; k++)
        t[i][k] = (i == k) ? ONE_Q : ZERO_Q;
    case (op)
      OP_TRANSLATE: begin
        t[0][3] = a[0]; t[1][3] = a[1]; t[2][3] = a[2];
      end
      OP_SCALE: begin
        t[0][0] = a[0]; t[1][1] = a[1]; t[2][2] = a[2];
      end
      OP_ROTX: begin
        t[1][1] = a[0]; t[1][2] = negate(a[1]); t[2][1] = a[1]; t[2][2] = a[0];
      end
      OP_ROTY: begin
        t[0][0] = a[0]; t[0][2] = a[1]; t[2][0] = negate(a[1]); t[2][2] = a[0];
      end
      OP_ROTZ: begin
        t[0][0] = a[0]; t[0][1] = negate(a[1]); t[1][0] = a[1]; t[1][1] = a[0];
      end
      OP_BASIS: begin
        for (int i = 0; i < 3; i++)
          for (int k = 0; k < 3; k++)
            t[i][k] = a[i*3+k];
      end
      OP_SHEARZ: begin
        t[0][2] = a[0]; t[1][2] = a[1];
      end
      OP_SHEAR2D: begin
        t[0][1] = a[0]; t[1][0] = a[1];
      end
      OP_PERSP: begin
        t[3][3] = ZERO_Q; t[3][2] = a[0];
      end
      default: premul = 1'b0;
    endcase
    if (premul) begin
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 4; j++) begin
          s = '0;
          for (int k = 0; k < 4; k++)
            s += fx_mul(t[i][k], shadow_m[k][j]);
          nm[i][j] = clamp32(s);
        end
      shadow_m = nm;
    end
    case (op)
      OP_CLEAR: begin
        for (int i = 0; i < 4; i++)
          for (int k = 0; k < 4; k++)
            shadow_m[i][k] = ZERO_Q;
      end
      OP_IDENTITY: begin
        for (int i = 0; i < 4; i++)
          for (int k = 0; k < 4; k++)
            shadow_m[i][k] = (i == k) ? ONE_Q : ZERO_Q;
      end
      OP_SET: shadow_m[r][c] = a[0];
      OP_TRANSPOSE: begin
        for (int i = 0; i < 4; i++)
          for (int k = 0; k < i; k++) begin
            x = shadow_m[i][k];
            shadow_m[i][k] = shadow_m[k][i];
            shadow_m[k][i] = x;
          end
      end
      OP_TRANSFORM: begin
        for (int i = 0; i < 4; i++) begin
          s = '0;
          for (int k = 0; k < 4; k++)
            s += fx_mul(shadow_m[i][k], a[k]);
          x = clamp32(s);
          case (i)
            0: res.r0 = x;
            1: res.r1 = x;
            2: res.r2 = x;
            default: res.r3 = x;
          endcase
        end
      end
      OP_READ: res.r0 = shadow_m[r][c];
      default: ;
    endcase
    res.sat = sat_seen;
    return res;
  endfunction

  // Predict on every accepted request, compare on every accepted result.
  always @(posedge clk) begin
    logic signed [31:0] args [0:8];
    htu_result_t        got, want;
    if (!rst_n) begin
      fail_count <= 0;
      expected_results.delete();
      for (int i = 0; i < 4; i++)
        for (int k = 0; k < 4; k++)
          shadow_m[i][k] = (i == k) ? ONE_Q : ZERO_Q;
    end else begin
      if (in_tvalid && in_tready) begin
        for (int k = 0; k < 9; k++)
          args[k] = in_tdata[4+32*k +: 32];
        expected_results.push_back(apply_request(op_t'(in_tuser), in_tdata[1:0],
                                                 in_tdata[3:2], args));
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata[127:96], out_tdata[95:64], out_tdata[63:32], out_tdata[31:0],
               out_tuser[0]};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected r0=%h r1=%h r2=%h r3=%h sat=%b", $time,
                     want.r0, want.r1, want.r2, want.r3, want.sat);
            $display("%0t:           actual   r0=%h r1=%h r2=%h r3=%h sat=%b", $time,
                     got.r0, got.r1, got.r2, got.r3, got.sat);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/homogeneous_transform_unit_tb.sv =====
// Top of the transform unit testbench: clock, reset, request stimulus, verdict.
// Depends on htu_pkg, homogeneous_transform_unit and htu_checker.
module homogeneous_transform_unit_tb;
  import htu_pkg::*;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [295:0] in_tdata = '0;
  logic [3:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic [0:0]   out_tuser;
  int           fail_count;
  int           pending_count;
  bit           stall_mode;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  homogeneous_transform_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  htu_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .fail_count(fail_count), .pending_count(pending_count)
  );

  // Receiver stalls: phases of always-ready alternate with phases of random stalls.
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0)
      stall_mode <= ~stall_mode;
    out_tready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
  end

  // Operand mixing small Q16.16 values with extremes and raw random words.
  function automatic logic [31:0] pick_arg();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom();
      3: return 32'h00010000;
      4: return 32'hffff0000;
      default: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
    endcase
  endfunction

  // Issue one request and wait until it is accepted.
  task automatic send_request(op_t op, logic [1:0] r, logic [1:0] c,
                              logic [31:0] a0, logic [31:0] a1, bit rand_rest);
    logic [295:0] d;
    d = '0;
    d[1:0] = r;
    d[3:2] = c;
    for (int k = 0; k < 9; k++)
      d[4+32*k +: 32] = rand_rest ? pick_arg() : 32'h0;
    d[4 +: 32] = a0;
    d[36 +: 32] = a1;
    in_tdata  <= d;
    in_tuser  <= op;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic go_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int burst;
    op_t op;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every opcode, field extremes, sine negation overflow.
    send_request(OP_READ, 2'd0, 2'd0, 0, 0, 0);
    send_request(OP_SET, 2'd3, 2'd3, 32'h7fffffff, 0, 0);
    send_request(OP_READ, 2'd3, 2'd3, 0, 0, 0);
    send_request(OP_TRANSFORM, 2'd0, 2'd0, 32'h7fffffff, 32'h80000000, 1);
    send_request(OP_ROTX, 2'd0, 2'd0, 32'h00010000, 32'h80000000, 0);
    send_request(OP_ROTY, 2'd1, 2'd2, 32'h0000b505, 32'h80000000, 0);
    send_request(OP_ROTZ, 2'd2, 2'd1, 32'h0000b505, 32'h0000b505, 0);
    send_request(OP_TRANSPOSE, 2'd0, 2'd0, 0, 0, 0);
    send_request(OP_TRANSLATE, 2'd0, 2'd0, 32'h7fffffff, 32'h80000000, 1);
    send_request(OP_SCALE, 2'd0, 2'd0, 32'h7fffffff, 32'h80000000, 1);
    send_request(OP_BASIS, 2'd0, 2'd0, 32'h00010000, 0, 1);
    send_request(OP_SHEARZ, 2'd0, 2'd0, 32'h00008000, 32'hffff8000, 0);
    send_request(OP_SHEAR2D, 2'd0, 2'd0, 32'h00008000, 32'h7fffffff, 0);
    send_request(OP_PERSP, 2'd0, 2'd0, 32'h00004000, 0, 0);
    send_request(OP_TRANSFORM, 2'd0, 2'd0, 32'hffffffff, 32'h00010000, 1);
    send_request(OP_NONE, 2'd3, 2'd3, 32'hffffffff, 32'hffffffff, 1);
    send_request(OP_CLEAR, 2'd0, 2'd0, 0, 0, 0);
    send_request(OP_TRANSFORM, 2'd0, 2'd0, 32'h00010000, 32'h00010000, 1);
    send_request(OP_IDENTITY, 2'd0, 2'd0, 0, 0, 0);
    send_request(OP_TRANSFORM, 2'd0, 2'd0, 32'h7fffffff, 32'h7fffffff, 1);
    go_idle();

    // Random: bursts of requests, weighted towards transforms, with occasional resets of
    // the matrix so that values do not stay saturated for long.
    for (int n = 0; n < 1400; ) begin
      burst = $urandom_range(1, 30);
      for (int b = 0; b < burst; b++, n++) begin
        case ($urandom_range(0, 19))
          0: op = OP_IDENTITY;
          1, 2, 3, 4, 5, 6: op = OP_TRANSFORM;
          default: op = op_t'($urandom_range(0, 15));
        endcase
        send_request(op, 2'($urandom), 2'($urandom), pick_arg(), pick_arg(), 1);
      end
      if ($urandom_range(0, 2) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    go_idle();

    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("** homogeneous_transform_unit: PASSED **");
    else
      $display("** homogeneous_transform_unit: FAILED **");
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("** homogeneous_transform_unit: FAILED **");
    $finish;
  end

endmodule
